### rtl/ibus_pkg.sv
// Constants, types and result codes shared by the serial-bus frame parser.
`timescale 1ns / 1ps

package ibus_pkg;

   localparam int unsigned NUM_CHANNELS = 14;
   localparam int unsigned SLOTS        = 14;
   localparam int unsigned FRAME_BYTES  = 32;

   localparam int unsigned POS_W = $clog2(FRAME_BYTES);
   localparam int unsigned IDX_W = 4;

   typedef logic [7:0]       byte_type;
   typedef logic [1:0]       status_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [15:0]      word_type;
   typedef logic [POS_W-1:0] pos_type;

   localparam byte_type HDR0 = 8'h20;
   localparam byte_type HDR1 = 8'h40;

   localparam word_type CSUM_INIT  = 16'hFFFF;
   localparam word_type CSUM_START = CSUM_INIT - {8'h00, HDR0};

   localparam status_type ST_CHANNEL = 2'd0;
   localparam status_type ST_SYNC    = 2'd1;
   localparam status_type ST_CSUM    = 2'd2;

   localparam pos_type POS_HUNT  = '0;
   localparam pos_type POS_HDR1  = pos_type'(1);
   localparam pos_type POS_CSUM0 = pos_type'(FRAME_BYTES - 2);

   localparam idx_type LAST_IDX = idx_type'(NUM_CHANNELS - 1);

endpackage

### rtl/ibus_req_if.sv
// Request channel carrying one received byte and its line-error flag.
`timescale 1ns / 1ps

interface ibus_req_if;
   import ibus_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;
   logic     line_error;

   modport source (output valid, output rx_byte, output line_error, input ready);
   modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

### rtl/ibus_rsp_if.sv
// Result channel carrying channel values and error reports.
`timescale 1ns / 1ps

interface ibus_rsp_if;
   import ibus_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   idx_type    channel_index;
   word_type   channel_value;
   logic       last;

   modport source (output valid, output status, output channel_index,
                   output channel_value, output last, input ready);
   modport sink   (input valid, input status, input channel_index,
                   input channel_value, input last, output ready);
endinterface

### rtl/ibus_frame_parser.sv
// Frame parser for the 32-byte servo-receiver serial frame.
//
// Requests arrive on req, one received byte each with a line-error flag.
// Results leave on rsp: a sync error for a rejected header byte, a checksum
// error at the end of a corrupted frame, or the channel values of a good
// frame in ascending order with last set on the final one.
// The parser works on one request at a time: req.ready is high only while
// it is idle. A byte is registered when taken and processed in the next
// cycle by a single 16-bit subtract and compare unit. A byte that gives
// results then emits them one at a time from the output register, so the
// closing byte of a good frame gives NUM_CHANNELS results in turn.
// When the receiver holds rsp.ready low, the result waits in the output
// register and no further request is accepted.
// Reset returns the parser to header hunting with the checksum preset.
// The channel buffer is not cleared; every channel emitted is written by the
// same frame.
`timescale 1ns / 1ps

module ibus_frame_parser (
   input  logic       clock,
   input  logic       reset,
   ibus_req_if.sink   req,
   ibus_rsp_if.source rsp
);
   import ibus_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PROC = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   pos_type    pos_ff, pos_in;
   word_type   csum_ff, csum_in;
   byte_type   hold_ff, hold_in;
   byte_type   byte_ff, byte_in;
   logic       err_ff, err_in;
   status_type status_ff, status_in;
   idx_type    idx_ff, idx_in;
   word_type   value_ff, value_in;
   logic       last_ff, last_in;

   word_type   chan_ff [SLOTS];
   logic       chan_wr_en;
   idx_type    chan_wr_slot;

   word_type   csum_diff;
   word_type   rx_word;
   pos_type    slot_pos;
   idx_type    idx_next;

   assign csum_diff = csum_ff - {8'h00, byte_ff};
   assign rx_word   = {byte_ff, hold_ff};
   assign slot_pos  = pos_ff - pos_type'(3);
   assign idx_next  = idx_ff + idx_type'(1);

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = (state_ff == S_OUT);
   assign rsp.status        = status_ff;
   assign rsp.channel_index = idx_ff;
   assign rsp.channel_value = value_ff;
   assign rsp.last          = last_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      csum_in      = csum_ff;
      hold_in      = hold_ff;
      byte_in      = byte_ff;
      err_in       = err_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      chan_wr_en   = 1'b0;
      chan_wr_slot = slot_pos[IDX_W:1];

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               byte_in  = req.rx_byte;
               err_in   = req.line_error;
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            state_in  = S_IDLE;
            status_in = ST_SYNC;
            idx_in    = '0;
            value_in  = '0;
            last_in   = 1'b1;
            priority if (err_ff) begin
               pos_in  = POS_HUNT;
               csum_in = CSUM_INIT;
            end else if (pos_ff == POS_HUNT) begin
               if (byte_ff != HDR0) begin
                  state_in = S_OUT;
               end else begin
                  pos_in  = POS_HDR1;
                  csum_in = CSUM_START;
               end
            end else if (pos_ff == POS_HDR1) begin
               if (byte_ff != HDR1) begin
                  state_in = S_OUT;
                  if (byte_ff == HDR0) begin
                     pos_in  = POS_HDR1;
                     csum_in = CSUM_START;
                  end else begin
                     pos_in  = POS_HUNT;
                     csum_in = CSUM_INIT;
                  end
               end else begin
                  csum_in = csum_diff;
                  pos_in  = pos_ff + pos_type'(1);
               end
            end else if (pos_ff < POS_CSUM0) begin
               csum_in = csum_diff;
               pos_in  = pos_ff + pos_type'(1);
               if (!pos_ff[0]) begin
                  hold_in = byte_ff;
               end else begin
                  chan_wr_en = 1'b1;
               end
            end else if (pos_ff == POS_CSUM0) begin
               hold_in = byte_ff;
               pos_in  = pos_ff + pos_type'(1);
            end else begin
               pos_in   = POS_HUNT;
               csum_in  = CSUM_INIT;
               state_in = S_OUT;
               if (rx_word != csum_ff) begin
                  status_in = ST_CSUM;
               end else begin
                  status_in = ST_CHANNEL;
                  value_in  = chan_ff[0];
                  last_in   = (LAST_IDX == '0);
               end
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               if (status_ff == ST_CHANNEL && !last_ff) begin
                  idx_in   = idx_next;
                  value_in = chan_ff[idx_next];
                  last_in  = (idx_next == LAST_IDX);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= POS_HUNT;
         csum_ff  <= CSUM_INIT;
         hold_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         csum_ff  <= csum_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      err_ff    <= err_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
      if (chan_wr_en) begin
         chan_ff[chan_wr_slot] <= rx_word;
      end
   end

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request accepted while a result is pending");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_CHANNEL) |-> rsp.last)
      else $error("error result without last");

   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_CHANNEL && rsp.last) |->
      (rsp.channel_index == LAST_IDX))
      else $error("final channel result at the wrong index");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("parser ready in the cycle after taking a request");
`endif

endmodule
